FILE: hw/rtl/kcl_pkg.sv
// Shared types, key codes and status codes for the keypad code lock.
`default_nettype none

package kcl_pkg;

  // Default code length limits
  localparam int unsigned MaxDigitsDef = 8;
  localparam int unsigned MinDigitsDef = 4;

  typedef logic [3:0] digit_t;

  // Key codes
  localparam logic [3:0] KeyDigitMax = 4'd9;
  localparam logic [3:0] KeyA        = 4'd10;
  localparam logic [3:0] KeyB        = 4'd11;
  localparam logic [3:0] NoEcho      = 4'd15;

  // Failure counter limits
  localparam logic [2:0] MaxFailReset = 3'd3;
  localparam logic [2:0] FailSat      = 3'd7;

  typedef enum logic [3:0] {
    StAccept    = 4'd0,
    StUnlocked  = 4'd1,
    StWrongCode = 4'd2,
    StLockedOut = 4'd3,
    StIgnored   = 4'd4,
    StReleased  = 4'd5,
    StEnterNew  = 4'd6,
    StConfirm   = 4'd7,
    StChangeOk  = 4'd8,
    StChangeErr = 4'd9,
    StBoxClosed = 4'd10
  } status_e;

  typedef struct packed {
    logic lockout;
    logic unlocked;
    logic change;
    logic confirm;
  } mode_t;

  // Factory code 1234, zeros beyond
  function automatic digit_t reset_digit(input int unsigned idx);
    digit_t d;
    case (idx)
      0:       d = 4'd1;
      1:       d = 4'd2;
      2:       d = 4'd3;
      3:       d = 4'd4;
      default: d = 4'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/kcl_code_match.sv
// Parallel comparison of two digit codes over their entered length.
`default_nettype none

module kcl_code_match #(
  parameter int unsigned MAX_DIGITS = kcl_pkg::MaxDigitsDef
) (
  input  kcl_pkg::digit_t [MAX_DIGITS-1:0]        a_i,
  input  logic [$clog2(MAX_DIGITS+2)-1:0]          a_len_i,
  input  kcl_pkg::digit_t [MAX_DIGITS-1:0]        b_i,
  input  logic [$clog2(MAX_DIGITS+2)-1:0]          b_len_i,
  output logic                                     match_o
);
  import kcl_pkg::*;

  localparam int unsigned LenW = $clog2(MAX_DIGITS + 2);
  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_DIGITS);

  logic [MAX_DIGITS-1:0] mismatch;

  // Flag differing digits inside the entered length
  always_comb begin
    mismatch = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if ((LenW'(i) < a_len_i) && (a_i[i] != b_i[i])) begin
        mismatch[i] = 1'b1;
      end
    end
  end

  // Too-long entries never match
  assign match_o = (a_len_i == b_len_i) && (a_len_i <= MaxLen) && !(|mismatch);

endmodule

`default_nettype wire

FILE: hw/rtl/keypad_code_lock.sv
// Top level of the keypad code lock: event handling, code storage and handshakes.
`default_nettype none

// Keypad code lock. Takes one keypad event word per cycle unless stalled (key code,
// box-off and key-switch levels) and returns one status word per event, in order.
// Each word passes an input register and then a result register, which holds its
// status; the whole decision (including the parallel digit compares) is made
// combinationally between the two, which sets the rate of one word per clock.
// in_stall_o rises only when the input register holds a word and the result register
// is full and stalled. The failure limit register is written through the cfg port at
// any time the lock is idle; it resets to 3.
module keypad_code_lock #(
  parameter int unsigned MAX_DIGITS = kcl_pkg::MaxDigitsDef,
  parameter int unsigned MIN_DIGITS = kcl_pkg::MinDigitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration write
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_max_failures_i,
  // event input
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [3:0] key_code_i,
  input  logic       box_off_i,
  input  logic       key_switch_i,
  // status output
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] status_o,
  output logic [3:0] echo_key_o,
  output logic       is_unlocked_o,
  output logic [2:0] failure_count_o
);
  import kcl_pkg::*;

  localparam int unsigned LenW = $clog2(MAX_DIGITS + 2);
  localparam int unsigned IdxW = $clog2(MAX_DIGITS);
  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_DIGITS);
  localparam logic [LenW-1:0] MinLen = LenW'(MIN_DIGITS);
  localparam logic [LenW-1:0] ResetLen = LenW'(4);

  // Configuration
  logic [2:0] max_fail_q;

  // Input register
  logic       s1_valid_q;
  logic [3:0] key_q;
  logic       box_off_q;
  logic       key_sw_q;

  // Result register
  logic       out_valid_q;
  status_e    status_q;
  logic [3:0] echo_q;
  logic       unlocked_out_q;
  logic [2:0] fail_out_q;

  // Lock state
  digit_t [MAX_DIGITS-1:0] stored_q;
  digit_t [MAX_DIGITS-1:0] entry_q;
  digit_t [MAX_DIGITS-1:0] new_q;
  digit_t [MAX_DIGITS-1:0] conf_q;
  logic [LenW-1:0] stored_len_q, stored_len_d;
  logic [LenW-1:0] entry_len_q, entry_len_d;
  logic [LenW-1:0] new_len_q, new_len_d;
  logic [LenW-1:0] conf_len_q, conf_len_d;
  logic [2:0]      fail_q, fail_d;
  mode_t           mode_q, mode_d;

  logic    advance, fire;
  logic    entry_match, change_match;
  logic    push_entry, push_new, push_conf, commit;
  logic [2:0] fail_inc;
  status_e status_d;
  logic [3:0] echo_d;

  // Handshakes
  assign cfg_ready_o = 1'b1;
  assign advance     = !out_valid_q || !out_stall_i;
  assign fire        = s1_valid_q && advance;
  assign in_stall_o  = s1_valid_q && !advance;

  kcl_code_match #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_entry_match (
    .a_i     (entry_q),
    .a_len_i (entry_len_q),
    .b_i     (stored_q),
    .b_len_i (stored_len_q),
    .match_o (entry_match)
  );

  kcl_code_match #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_change_match (
    .a_i     (new_q),
    .a_len_i (new_len_q),
    .b_i     (conf_q),
    .b_len_i (conf_len_q),
    .match_o (change_match)
  );

  // Decide the event held in the input register
  always_comb begin
    mode_d       = mode_q;
    fail_d       = fail_q;
    stored_len_d = stored_len_q;
    entry_len_d  = entry_len_q;
    new_len_d    = new_len_q;
    conf_len_d   = conf_len_q;
    status_d     = StAccept;
    echo_d       = NoEcho;
    push_entry   = 1'b0;
    push_new     = 1'b0;
    push_conf    = 1'b0;
    commit       = 1'b0;
    fail_inc     = (fail_q == FailSat) ? FailSat : fail_q + 3'd1;

    if (box_off_q) begin
      mode_d.unlocked = 1'b0;
      mode_d.change   = 1'b0;
      mode_d.confirm  = 1'b0;
      new_len_d       = '0;
      conf_len_d      = '0;
      status_d        = StBoxClosed;
    end else if (mode_q.lockout) begin
      if (key_sw_q) begin
        mode_d.lockout = 1'b0;
        fail_d         = '0;
        status_d       = StReleased;
      end else begin
        status_d = StLockedOut;
      end
    end else begin
      case (key_q) inside
        [4'd0:KeyDigitMax]: begin
          echo_d = key_q;
          if (mode_q.change && mode_q.confirm) begin
            push_conf = 1'b1;
            if (conf_len_q <= MaxLen) conf_len_d = conf_len_q + LenW'(1);
          end else if (mode_q.change) begin
            push_new = 1'b1;
            if (new_len_q <= MaxLen) new_len_d = new_len_q + LenW'(1);
          end else begin
            push_entry = 1'b1;
            if (entry_len_q <= MaxLen) entry_len_d = entry_len_q + LenW'(1);
          end
        end
        KeyA: begin
          echo_d = key_q;
          if (mode_q.unlocked) begin
            if (entry_match) begin
              fail_d         = '0;
              mode_d.change  = 1'b1;
              mode_d.confirm = 1'b0;
              new_len_d      = '0;
              conf_len_d     = '0;
              status_d       = StEnterNew;
            end else begin
              fail_d = fail_inc;
              if (fail_inc >= max_fail_q) begin
                mode_d.lockout = 1'b1;
                status_d       = StLockedOut;
              end else begin
                status_d = StWrongCode;
              end
            end
            entry_len_d = '0;
          end else begin
            status_d = StIgnored;
          end
        end
        KeyB: begin
          if (mode_q.change && !mode_q.confirm) begin
            echo_d         = key_q;
            mode_d.confirm = 1'b1;
            conf_len_d     = '0;
            status_d       = StConfirm;
          end else if (mode_q.change) begin
            if ((new_len_q >= MinLen) && (new_len_q <= MaxLen) && change_match) begin
              commit       = 1'b1;
              stored_len_d = new_len_q;
              status_d     = StChangeOk;
            end else begin
              status_d = StChangeErr;
            end
            fail_d         = '0;
            mode_d.change  = 1'b0;
            mode_d.confirm = 1'b0;
            new_len_d      = '0;
            conf_len_d     = '0;
          end else begin
            if (entry_match) begin
              mode_d.unlocked = 1'b1;
              fail_d          = '0;
              status_d        = StUnlocked;
            end else begin
              fail_d = fail_inc;
              if (fail_inc >= max_fail_q) begin
                mode_d.lockout = 1'b1;
                status_d       = StLockedOut;
              end else begin
                status_d = StWrongCode;
              end
            end
            entry_len_d = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_fail_q   <= MaxFailReset;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      stored_len_q <= ResetLen;
      entry_len_q  <= '0;
      new_len_q    <= '0;
      conf_len_q   <= '0;
      fail_q       <= '0;
      mode_q       <= '0;
      for (int i = 0; i < MAX_DIGITS; i++) begin
        stored_q[i] <= reset_digit(i);
      end
    end else begin
      if (cfg_valid_i && cfg_ready_o) max_fail_q <= cfg_max_failures_i;
      // advance the input register
      if (!in_stall_o) s1_valid_q <= in_valid_i;
      // advance the result register
      if (advance) out_valid_q <= s1_valid_q;
      if (fire) begin
        stored_len_q <= stored_len_d;
        entry_len_q  <= entry_len_d;
        new_len_q    <= new_len_d;
        conf_len_q   <= conf_len_d;
        fail_q       <= fail_d;
        mode_q       <= mode_d;
        if (commit) begin
          for (int i = 0; i < MAX_DIGITS; i++) begin
            stored_q[i] <= (LenW'(i) < new_len_q) ? new_q[i] : '0;
          end
        end
      end
    end
  end

  // Payload registers and digit buffers
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      key_q     <= key_code_i;
      box_off_q <= box_off_i;
      key_sw_q  <= key_switch_i;
    end
    if (fire) begin
      status_q       <= status_d;
      echo_q         <= echo_d;
      unlocked_out_q <= mode_d.unlocked;
      fail_out_q     <= fail_d;
      // store digits; drop those past the buffer
      if (push_entry && (entry_len_q < MaxLen)) entry_q[entry_len_q[IdxW-1:0]] <= key_q;
      if (push_new && (new_len_q < MaxLen))     new_q[new_len_q[IdxW-1:0]]     <= key_q;
      if (push_conf && (conf_len_q < MaxLen))   conf_q[conf_len_q[IdxW-1:0]]   <= key_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign echo_key_o      = echo_q;
  assign is_unlocked_o   = unlocked_out_q;
  assign failure_count_o = fail_out_q;

  // Checks
  a_confirm_in_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q.confirm |-> mode_q.change)
    else $error("confirm flag set outside change mode");

  a_change_when_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q.change |-> mode_q.unlocked)
    else $error("change mode while box not unlocked");

  a_stored_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stored_len_q <= MaxLen)
    else $error("stored code length out of range");

  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty input register");

  a_unlock_clears_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q == StUnlocked)) |-> (fail_out_q == 3'd0))
    else $error("failure count not cleared on unlock");

endmodule

`default_nettype wire

FILE: test/keypad_code_lock_tb.sv
// Self-checking testbench for the keypad code lock: random keypad traffic against a predictor.
`timescale 1ns / 1ps

module keypad_code_lock_tb;
  import kcl_pkg::*;

  localparam int unsigned Digits    = MaxDigitsDef;
  localparam int unsigned MinLength = MinDigitsDef;
  localparam int unsigned TotalItems = 1450;

  typedef struct packed {
    logic [3:0] key;
    logic       box_off;
    logic       key_sw;
  } key_event_t;

  typedef struct packed {
    status_e    status;
    logic [3:0] echo;
    logic       unlocked;
    logic [2:0] fails;
  } lock_status_t;

  // DUT ports
  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [2:0] cfg_max_failures_i = MaxFailReset;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [3:0] key_code_i = 4'd15;
  logic       box_off_i = 1'b0;
  logic       key_switch_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [3:0] status_o;
  logic [3:0] echo_key_o;
  logic       is_unlocked_o;
  logic [2:0] failure_count_o;

  keypad_code_lock dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_max_failures_i(cfg_max_failures_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .key_code_i        (key_code_i),
    .box_off_i         (box_off_i),
    .key_switch_i      (key_switch_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .echo_key_o        (echo_key_o),
    .is_unlocked_o     (is_unlocked_o),
    .failure_count_o   (failure_count_o)
  );

  // Predicted lock state; digit i sits in nibble i
  logic [31:0] code_digits = 32'h0000_4321;  // factory code 1234
  logic [3:0]  code_len = 4'd4;
  logic [31:0] entry_digits = '0;
  logic [3:0]  entry_len = '0;
  logic [31:0] new_digits = '0;
  logic [3:0]  new_len = '0;
  logic [31:0] confirm_digits = '0;
  logic [3:0]  confirm_len = '0;
  logic [2:0]  fail_cnt = '0;
  logic [2:0]  fail_limit = MaxFailReset;
  mode_t       mode = '0;

  key_event_t   key_events[$];
  lock_status_t awaited[$];
  key_event_t   cur_ev = '0;
  lock_status_t got_expect;
  int unsigned  sent = 0;
  int unsigned  mismatches = 0;
  int unsigned  tx_wait = 0;
  int unsigned  rx_wait = 0;
  bit           tx_calm = 1'b0;
  bit           rx_calm = 1'b0;
  bit           long_hold = 1'b0;
  bit           hold_go = 1'b0;

  int unsigned ph_mark [3] = '{400, 700, 1000};
  logic [2:0]  ph_limit [3] = '{3'd7, 3'd2, 3'd5};

  // Clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  // Append a digit; a ninth digit only bumps the length to mark the entry too long
  function automatic void push_digit(inout logic [31:0] digs, inout logic [3:0] len,
                                     input logic [3:0] d);
    if (len < Digits) digs[4*len +: 4] = d;
    if (len <= Digits) len = len + 4'd1;
  endfunction

  function automatic bit same_code(input logic [31:0] a, input logic [3:0] alen,
                                   input logic [31:0] b, input logic [3:0] blen);
    bit eq;
    eq = (alen == blen) && (alen <= Digits);
    for (int i = 0; i < Digits; i++) begin
      if (eq && i < alen && a[4*i +: 4] != b[4*i +: 4]) eq = 1'b0;
    end
    return eq;
  endfunction

  function automatic status_e count_failure();
    if (fail_cnt < FailSat) fail_cnt = fail_cnt + 3'd1;
    if (fail_cnt >= fail_limit) begin
      mode.lockout = 1'b1;
      return StLockedOut;
    end
    return StWrongCode;
  endfunction

  // Apply one keypad event to the predicted state and return its status word
  function automatic lock_status_t advance_lock(input key_event_t ev);
    lock_status_t r;
    r.status = StAccept;
    r.echo   = NoEcho;
    if (ev.box_off) begin
      mode.unlocked = 1'b0;
      mode.change   = 1'b0;
      mode.confirm  = 1'b0;
      new_len       = '0;
      confirm_len   = '0;
      r.status      = StBoxClosed;
    end else if (mode.lockout) begin
      if (ev.key_sw) begin
        mode.lockout = 1'b0;
        fail_cnt     = '0;
        r.status     = StReleased;
      end else begin
        r.status = StLockedOut;
      end
    end else if (ev.key <= KeyDigitMax) begin
      r.echo = ev.key;
      if (mode.change && mode.confirm) push_digit(confirm_digits, confirm_len, ev.key);
      else if (mode.change) push_digit(new_digits, new_len, ev.key);
      else push_digit(entry_digits, entry_len, ev.key);
    end else if (ev.key == KeyA) begin
      r.echo = ev.key;
      if (mode.unlocked) begin
        if (same_code(entry_digits, entry_len, code_digits, code_len)) begin
          fail_cnt     = '0;
          mode.change  = 1'b1;
          mode.confirm = 1'b0;
          new_len      = '0;
          confirm_len  = '0;
          r.status     = StEnterNew;
        end else begin
          r.status = count_failure();
        end
        entry_len = '0;
      end else begin
        r.status = StIgnored;
      end
    end else if (ev.key == KeyB) begin
      if (mode.change && !mode.confirm) begin
        r.echo       = ev.key;
        mode.confirm = 1'b1;
        confirm_len  = '0;
        r.status     = StConfirm;
      end else if (mode.change) begin
        // Commit: zero every stored digit past the new length
        if (new_len >= MinLength && new_len <= Digits &&
            same_code(new_digits, new_len, confirm_digits, confirm_len)) begin
          code_digits = '0;
          for (int i = 0; i < Digits; i++) begin
            if (i < new_len) code_digits[4*i +: 4] = new_digits[4*i +: 4];
          end
          code_len = new_len;
          r.status = StChangeOk;
        end else begin
          r.status = StChangeErr;
        end
        fail_cnt     = '0;
        mode.change  = 1'b0;
        mode.confirm = 1'b0;
        new_len      = '0;
        confirm_len  = '0;
      end else begin
        if (same_code(entry_digits, entry_len, code_digits, code_len)) begin
          mode.unlocked = 1'b1;
          fail_cnt      = '0;
          r.status      = StUnlocked;
        end else begin
          r.status = count_failure();
        end
        entry_len = '0;
      end
    end
    r.unlocked = mode.unlocked;
    r.fails    = fail_cnt;
    return r;
  endfunction

  // ---------------------------------------------------------------- driver / monitor

  function automatic int unsigned pick_gap(input bit calm);
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  // Offer queued words; hold a stalled word, draw a gap after each accepted one
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tx_wait = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        awaited.push_back(advance_lock(cur_ev));
        if ($urandom_range(0, 39) == 0) tx_calm = ~tx_calm;
        tx_wait = long_hold ? 0 : pick_gap(tx_calm);
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (tx_wait > 0) begin
          tx_wait = tx_wait - 1;
          in_valid_i <= 1'b0;
        end else if (key_events.size() > 0) begin
          cur_ev = key_events.pop_front();
          key_code_i   <= cur_ev.key;
          box_off_i    <= cur_ev.box_off;
          key_switch_i <= cur_ev.key_sw;
          in_valid_i   <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  // Check each accepted status word and stall the output for a random gap after it
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (awaited.size() == 0) begin
          flag_error($sformatf("unexpected status word %0d", status_o));
        end else begin
          got_expect = awaited.pop_front();
          if (status_o !== got_expect.status || echo_key_o !== got_expect.echo ||
              is_unlocked_o !== got_expect.unlocked ||
              failure_count_o !== got_expect.fails)
            flag_error($sformatf(
              "expected status %0d echo %0d unlocked %0b failures %0d, got %0d %0d %0b %0d",
              got_expect.status, got_expect.echo, got_expect.unlocked, got_expect.fails,
              status_o, echo_key_o, is_unlocked_o, failure_count_o));
        end
        if ($urandom_range(0, 39) == 0) rx_calm = ~rx_calm;
        rx_wait = pick_gap(rx_calm);
      end
      if (rx_wait > 0) begin
        rx_wait = rx_wait - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= long_hold;
      end
    end
  end

  // Long receiver hold-off so the lock fills up and stalls its input
  initial begin
    @(posedge hold_go);
    long_hold <= 1'b1;
    repeat (120) @(posedge clk_i);
    long_hold <= 1'b0;
  end

  // ---------------------------------------------------------------- stimulus

  task automatic queue_event(input logic [3:0] key, input logic boff, input logic ksw);
    key_events.push_back('{key: key, box_off: boff, key_sw: ksw});
    sent++;
  endtask

  // Key in n digits; past the eighth, draw fresh ones
  task automatic queue_digits(input logic [31:0] c, input int unsigned n);
    logic [3:0] d;
    for (int i = 0; i < n; i++) begin
      d = (i < Digits) ? c[4*i +: 4] : 4'($urandom_range(0, 9));
      queue_event(d, 1'b0, 1'($urandom_range(0, 1)));
    end
  endtask

  function automatic logic [31:0] rand_digits();
    logic [31:0] c;
    for (int i = 0; i < Digits; i++) c[4*i +: 4] = 4'($urandom_range(0, 9));
    return c;
  endfunction

  // Change one digit among the first n to a different one
  function automatic logic [31:0] mutate_digit(input logic [31:0] c, input int unsigned n);
    int unsigned p;
    int unsigned d;
    if (n == 0) return c;
    p = $urandom_range(0, ((n > Digits) ? Digits : n) - 1);
    d = c[4*p +: 4];
    c[4*p +: 4] = 4'((d + 1 + $urandom_range(0, 8)) % 10);
    return c;
  endfunction

  task automatic queue_noise(input int unsigned n);
    repeat (n) queue_event(4'($urandom_range(0, 15)), $urandom_range(0, 7) == 0,
                           1'($urandom_range(0, 1)));
  endtask

  // One sequence, planned from the predicted state of the idle lock
  task automatic run_chunk();
    logic [31:0] c;
    logic [31:0] c2;
    int unsigned n;
    int unsigned n2;
    int unsigned kind;
    int unsigned r;
    kind = $urandom_range(0, 9);
    if (mode.lockout) queue_event(4'($urandom_range(0, 15)), 1'b0, 1'b1);
    case (kind)
      0, 1: begin
        c = code_digits;
        if ($urandom_range(0, 3) == 0) c = mutate_digit(c, code_len);
        queue_digits(c, code_len);
        queue_event(KeyB, 1'b0, 1'($urandom_range(0, 1)));
      end
      2, 3, 4: begin
        // unlock if needed, A check, new code, B, confirmation, B
        if (!mode.unlocked || mode.change) begin
          if (mode.change) queue_event(NoEcho, 1'b1, 1'b0);
          queue_digits(code_digits, code_len);
          queue_event(KeyB, 1'b0, 1'b0);
        end
        c = code_digits;
        if ($urandom_range(0, 5) == 0) c = mutate_digit(c, code_len);
        queue_digits(c, code_len);
        queue_event(KeyA, 1'b0, 1'($urandom_range(0, 1)));
        r = $urandom_range(0, 9);
        if (r == 0) n = $urandom_range(1, 3);
        else if (r == 1) n = $urandom_range(9, 10);
        else n = $urandom_range(MinLength, Digits);
        c = rand_digits();
        queue_digits(c, n);
        queue_event(KeyB, 1'b0, 1'($urandom_range(0, 1)));
        c2 = c;
        n2 = n;
        r = $urandom_range(0, 7);
        if (r == 0) c2 = mutate_digit(c2, n);
        else if (r == 1) n2 = (n > 1) ? n - 1 : n + 1;
        queue_digits(c2, n2);
        queue_event(KeyB, 1'b0, 1'($urandom_range(0, 1)));
      end
      5: begin
        // wrong codes up to lockout, ignored events, then the key switch
        repeat (fail_limit + 1) begin
          queue_digits(rand_digits(), $urandom_range(0, 9));
          queue_event(KeyB, 1'b0, 1'b0);
        end
        repeat ($urandom_range(1, 3)) queue_event(4'($urandom_range(0, 15)), 1'b0, 1'b0);
        queue_event(4'($urandom_range(0, 15)), 1'b0, 1'b1);
      end
      6: begin
        queue_digits(rand_digits(), $urandom_range(0, 6));
        queue_event(KeyA, 1'b0, 1'($urandom_range(0, 1)));
      end
      7, 8: begin
        queue_noise($urandom_range(3, 12));
        queue_event(KeyB, 1'b0, 1'b0);
      end
      default: begin
        // box off in the middle of an entry
        queue_digits(code_digits, $urandom_range(0, code_len));
        queue_event(4'($urandom_range(0, 15)), 1'b1, 1'($urandom_range(0, 1)));
        queue_digits(code_digits, code_len);
        queue_event(KeyB, 1'b0, 1'b0);
      end
    endcase
  endtask

  // Wait until no word is pending in either direction
  task automatic wait_drained();
    do @(negedge clk_i);
    while (key_events.size() != 0 || in_valid_i || awaited.size() != 0);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [2:0] v);
    @(posedge clk_i);
    cfg_valid_i        <= 1'b1;
    cfg_max_failures_i <= v;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    fail_limit = v;
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned ph;
    ph = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: no key extremes, A while locked, wrong and right codes,
    // box off, a too long entry, lockout and release
    queue_event(4'd12, 1'b0, 1'b0);
    queue_event(4'd15, 1'b0, 1'b1);
    queue_event(KeyA, 1'b0, 1'b0);
    queue_event(4'd0, 1'b0, 1'b0);
    queue_event(4'd9, 1'b0, 1'b1);
    queue_event(KeyB, 1'b0, 1'b0);
    queue_digits(code_digits, code_len);
    queue_event(KeyB, 1'b0, 1'b0);
    queue_event(4'd15, 1'b1, 1'b1);
    queue_digits(32'h7654_3210, 9);
    queue_event(KeyB, 1'b0, 1'b0);
    queue_event(KeyB, 1'b0, 1'b0);
    queue_event(KeyB, 1'b0, 1'b0);
    queue_event(4'd5, 1'b0, 1'b0);
    queue_event(KeyB, 1'b0, 1'b1);
    wait_drained();

    write_limit(3'd1);
    while (sent < TotalItems) begin
      if (ph < 3 && sent >= ph_mark[ph]) begin
        write_limit(ph_limit[ph]);
        if (ph == 1) begin
          hold_go = 1'b1;
          queue_noise(40);
          wait_drained();
        end
        ph++;
      end
      run_chunk();
      wait_drained();
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && awaited.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
